>>> design/sme_pkg.sv
// Shared types, operation codes and status codes for the stack machine execute block.
`timescale 1ns / 1ps
`default_nettype none

package sme_pkg;

  localparam int DATA_W  = 32;
  localparam int FUNC_W  = 5;
  localparam int DEPTH_W = 11;
  localparam int BR_W    = 2;
  localparam int STAT_W  = 3;

  // Operation codes of the input beat.
  localparam logic [FUNC_W-1:0] FN_PUSH  = 5'd0;
  localparam logic [FUNC_W-1:0] FN_ADD   = 5'd1;
  localparam logic [FUNC_W-1:0] FN_SUB   = 5'd2;
  localparam logic [FUNC_W-1:0] FN_MUL   = 5'd3;
  localparam logic [FUNC_W-1:0] FN_DIV   = 5'd4;
  localparam logic [FUNC_W-1:0] FN_MOD   = 5'd5;
  localparam logic [FUNC_W-1:0] FN_LT    = 5'd6;
  localparam logic [FUNC_W-1:0] FN_LE    = 5'd7;
  localparam logic [FUNC_W-1:0] FN_EQ    = 5'd8;
  localparam logic [FUNC_W-1:0] FN_NE    = 5'd9;
  localparam logic [FUNC_W-1:0] FN_POP   = 5'd10;
  localparam logic [FUNC_W-1:0] FN_OVER  = 5'd11;
  localparam logic [FUNC_W-1:0] FN_SWAP  = 5'd12;
  localparam logic [FUNC_W-1:0] FN_DUP   = 5'd13;
  localparam logic [FUNC_W-1:0] FN_DUP2  = 5'd14;
  localparam logic [FUNC_W-1:0] FN_IF    = 5'd15;
  localparam logic [FUNC_W-1:0] FN_ELSE  = 5'd16;
  localparam logic [FUNC_W-1:0] FN_ENDIF = 5'd17;

  // Conditional region modes.
  localparam logic [BR_W-1:0] BR_NONE = 2'd0;
  localparam logic [BR_W-1:0] BR_EXEC = 2'd1;
  localparam logic [BR_W-1:0] BR_SKIP = 2'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 3'd1;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 3'd2;
  localparam logic [STAT_W-1:0] ST_DIV_ZERO  = 3'd3;
  localparam logic [STAT_W-1:0] ST_SKIPPED   = 3'd4;

  typedef struct packed {
    logic        [FUNC_W-1:0] func;
    logic signed [DATA_W-1:0] immediate;
  } sme_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  top_value;
    logic signed [DATA_W-1:0]  popped_value;
    logic        [DEPTH_W-1:0] depth;
    logic        [BR_W-1:0]    branch_state;
    logic        [STAT_W-1:0]  status;
  } sme_out_t;

  // Operation of the iterative multiply / divide unit.
  typedef enum logic [1:0] {
    IOP_MUL,
    IOP_DIV,
    IOP_MOD
  } sme_iop_t;

  typedef struct packed {
    logic              start;
    sme_iop_t          op;
    logic [DATA_W-1:0] opa;
    logic [DATA_W-1:0] opb;
  } sme_iter_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] result;
  } sme_iter_rsp_t;

endpackage

`default_nettype wire

>>> design/sme_iter_unit.sv
// Iterative multiply, divide and modulo unit built around one shared adder.
`timescale 1ns / 1ps
`default_nettype none

module sme_iter_unit
  import sme_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire sme_iter_req_t req,
  output sme_iter_rsp_t      rsp
);

  typedef enum logic [4:0] {
    U_IDLE = 5'b00001,
    U_ABSA = 5'b00010,
    U_ABSB = 5'b00100,
    U_STEP = 5'b01000,
    U_FIN  = 5'b10000
  } sme_ustate_t;

  localparam int CNT_W = $clog2(DATA_W);

  sme_ustate_t       ustate_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  sme_iop_t          op_r;
  logic              neg_r;
  logic [DATA_W-1:0] acc_r;
  logic [DATA_W-1:0] opa_r;
  logic [DATA_W-1:0] opb_r;

  logic [DATA_W:0]   add_x;
  logic [DATA_W:0]   add_y;
  logic              add_sub;
  logic [DATA_W+1:0] add_sum;
  logic              add_ge;

  // Operand selection for the shared adder / subtractor.
  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_sub = 1'b0;
    unique case (ustate_r)
      U_ABSA: begin
        add_y   = {1'b0, opa_r};
        add_sub = opa_r[DATA_W-1];
      end
      U_ABSB: begin
        add_y   = {1'b0, opb_r};
        add_sub = opb_r[DATA_W-1];
      end
      U_STEP: begin
        if (op_r == IOP_MUL) begin
          add_x = {1'b0, acc_r};
          add_y = {1'b0, opa_r};
        end else begin
          add_x   = {acc_r, opa_r[DATA_W-1]};
          add_y   = {1'b0, opb_r};
          add_sub = 1'b1;
        end
      end
      U_FIN: begin
        add_y   = {1'b0, (op_r == IOP_DIV) ? opa_r : acc_r};
        add_sub = neg_r;
      end
      default: begin
      end
    endcase
  end

  assign add_sum = {1'b0, add_x} + (add_sub ? ~{1'b0, add_y} : {1'b0, add_y})
                 + (DATA_W+2)'(add_sub);
  assign add_ge  = ~add_sum[DATA_W+1];

  // Sequencer: magnitudes for divide and modulo, one bit per step, then the sign fix.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ustate_r <= U_IDLE;
      done_r   <= 1'b0;
    end else begin
      done_r <= (ustate_r == U_FIN);
      unique case (ustate_r)
        U_IDLE: begin
          if (req.start) begin
            ustate_r <= (req.op == IOP_MUL) ? U_STEP : U_ABSA;
          end
        end
        U_ABSA: ustate_r <= U_ABSB;
        U_ABSB: ustate_r <= U_STEP;
        U_STEP: begin
          if (cnt_r == CNT_W'(DATA_W - 1)) begin
            ustate_r <= U_FIN;
          end
        end
        U_FIN: ustate_r <= U_IDLE;
        default: ustate_r <= U_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (ustate_r)
      U_IDLE: begin
        if (req.start) begin
          op_r  <= req.op;
          opa_r <= req.opa;
          opb_r <= req.opb;
          acc_r <= '0;
          cnt_r <= '0;
          case (req.op)
            IOP_DIV: neg_r <= req.opa[DATA_W-1] ^ req.opb[DATA_W-1];
            IOP_MOD: neg_r <= req.opa[DATA_W-1];
            default: neg_r <= 1'b0;
          endcase
        end
      end
      U_ABSA: opa_r <= add_sum[DATA_W-1:0];
      U_ABSB: opb_r <= add_sum[DATA_W-1:0];
      U_STEP: begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (op_r == IOP_MUL) begin
          if (opb_r[0]) begin
            acc_r <= add_sum[DATA_W-1:0];
          end
          opa_r <= {opa_r[DATA_W-2:0], 1'b0};
          opb_r <= {1'b0, opb_r[DATA_W-1:1]};
        end else begin
          acc_r <= add_ge ? add_sum[DATA_W-1:0] : add_x[DATA_W-1:0];
          opa_r <= {opa_r[DATA_W-2:0], add_ge};
        end
      end
      U_FIN: acc_r <= add_sum[DATA_W-1:0];
      default: begin
      end
    endcase
  end

  assign rsp.done   = done_r;
  assign rsp.result = acc_r;

endmodule

`default_nettype wire

>>> design/stack_machine_execute.sv
// Top level of the stack machine execute block: sequencer, data stack memory and simple ALU.
//
// Usage: one input beat (in_data.func, in_data.immediate) carries one stack operation, and
// every accepted beat yields exactly one result beat on the out_ channel with the new top
// of stack, the value removed by pop or if, the depth, the conditional mode and a status.
// Both channels use valid / ready handshakes.
// Swap and dup2, when completed, make two stack writes through the single memory write
// port; multiply, divide and modulo run bit by bit through the shared iterative unit.
// One operation is in work at a time, so a new beat is not accepted before the result
// of the last one is loaded; it can be accepted from the cycle after that load.
// Reset empties the stack and leaves no conditional region open; the stack memory
// itself is not cleared, since only written entries are ever read.
// A result waits in the output register while out_ready is low; the next input beat is
// still accepted and worked on, and its result is held until the output register frees.
`timescale 1ns / 1ps
`default_nettype none

module stack_machine_execute
  import sme_pkg::*;
#(
  parameter int STACK_DEPTH = 1024
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire sme_in_t in_data,
  output logic         out_valid,
  input  wire logic    out_ready,
  output sme_out_t     out_data
);

  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int AW  = $clog2(STACK_DEPTH);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_ITER = 5'b00100,
    S_WR2  = 5'b01000,
    S_DONE = 5'b10000
  } sme_state_t;

  sme_state_t        state_r;
  logic [SPW-1:0]    sp_r;
  logic [BR_W-1:0]   mode_r;
  logic              out_valid_r;
  sme_out_t          out_data_r;

  logic [FUNC_W-1:0] func_r;
  logic [DATA_W-1:0] imm_r;
  logic [DATA_W-1:0] t_r;
  logic [DATA_W-1:0] s_r;
  logic [DATA_W-1:0] res_top_r;
  logic [DATA_W-1:0] res_pop_r;
  logic [STAT_W-1:0] res_stat_r;
  logic [AW-1:0]     wa2_r;
  logic [DATA_W-1:0] wd2_r;

  logic [DATA_W-1:0] stack_mem [STACK_DEPTH];

  logic [SPW-1:0]    sp_m1;
  logic [SPW-1:0]    sp_m2;
  logic [SPW-1:0]    sp_p1;
  logic [SPW-1:0]    sp_p2;
  logic [1:0]        need;
  logic [1:0]        room;
  logic              underflow;
  logic              overflow;
  logic [DATA_W-1:0] alu_val;

  logic [SPW-1:0]    ex_sp;
  logic [BR_W-1:0]   ex_mode;
  logic [DATA_W-1:0] ex_top;
  logic [DATA_W-1:0] ex_pop;
  logic [STAT_W-1:0] ex_stat;
  logic              ex_we1;
  logic [AW-1:0]     ex_wa1;
  logic [DATA_W-1:0] ex_wd1;
  logic              ex_wr2;
  logic [AW-1:0]     ex_wa2;
  logic [DATA_W-1:0] ex_wd2;
  logic              ex_go_iter;

  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [DATA_W-1:0] mem_wd;

  sme_iter_req_t     iter_req;
  sme_iter_rsp_t     iter_rsp;

  logic              out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;

  assign sp_m1 = sp_r - SPW'(1);
  assign sp_m2 = sp_r - SPW'(2);
  assign sp_p1 = sp_r + SPW'(1);
  assign sp_p2 = sp_r + SPW'(2);

  // Operand count and free room each stack operation requires.
  always_comb begin
    need = 2'd2;
    room = 2'd0;
    unique case (func_r) inside
      FN_PUSH: begin
        need = 2'd0;
        room = 2'd1;
      end
      FN_POP:  need = 2'd1;
      FN_OVER: room = 2'd1;
      FN_DUP: begin
        need = 2'd1;
        room = 2'd1;
      end
      FN_DUP2: room = 2'd2;
      default: begin
      end
    endcase
  end

  assign underflow = sp_r < SPW'(need);
  assign overflow  = ({1'b0, sp_r} + (SPW+1)'(room)) > (SPW+1)'(STACK_DEPTH);

  // Combinational arithmetic and compares: top entry against second entry.
  always_comb begin
    case (func_r)
      FN_ADD:  alu_val = t_r + s_r;
      FN_SUB:  alu_val = t_r - s_r;
      FN_LT:   alu_val = DATA_W'($signed(t_r) < $signed(s_r));
      FN_LE:   alu_val = DATA_W'($signed(t_r) <= $signed(s_r));
      FN_EQ:   alu_val = DATA_W'(t_r == s_r);
      FN_NE:   alu_val = DATA_W'(t_r != s_r);
      default: alu_val = '0;
    endcase
  end

  // Operation decode: new pointer, mode, result fields and stack writes.
  always_comb begin
    ex_sp      = sp_r;
    ex_mode    = mode_r;
    ex_top     = (sp_r != '0) ? t_r : '0;
    ex_pop     = '0;
    ex_stat    = ST_OK;
    ex_we1     = 1'b0;
    ex_wa1     = AW'(sp_r);
    ex_wd1     = imm_r;
    ex_wr2     = 1'b0;
    ex_wa2     = AW'(sp_m2);
    ex_wd2     = t_r;
    ex_go_iter = 1'b0;
    if (func_r <= FN_DUP2) begin
      if (mode_r == BR_SKIP) begin
        ex_stat = ST_SKIPPED;
      end else if (underflow) begin
        ex_stat = ST_UNDERFLOW;
      end else if (overflow) begin
        ex_stat = ST_OVERFLOW;
      end else begin
        unique case (func_r) inside
          FN_PUSH: begin
            ex_we1 = 1'b1;
            ex_sp  = sp_p1;
            ex_top = imm_r;
          end
          FN_ADD, FN_SUB, FN_LT, FN_LE, FN_EQ, FN_NE: begin
            ex_we1 = 1'b1;
            ex_wa1 = AW'(sp_m2);
            ex_wd1 = alu_val;
            ex_sp  = sp_m1;
            ex_top = alu_val;
          end
          FN_MUL: ex_go_iter = 1'b1;
          FN_DIV, FN_MOD: begin
            if (s_r == '0) begin
              ex_stat = ST_DIV_ZERO;
            end else begin
              ex_go_iter = 1'b1;
            end
          end
          FN_POP: begin
            ex_pop = t_r;
            ex_sp  = sp_m1;
            ex_top = (sp_r >= SPW'(2)) ? s_r : '0;
          end
          FN_OVER: begin
            ex_we1 = 1'b1;
            ex_wd1 = s_r;
            ex_sp  = sp_p1;
            ex_top = s_r;
          end
          FN_SWAP: begin
            ex_we1 = 1'b1;
            ex_wa1 = AW'(sp_m1);
            ex_wd1 = s_r;
            ex_wr2 = 1'b1;
            ex_top = s_r;
          end
          FN_DUP: begin
            ex_we1 = 1'b1;
            ex_wd1 = t_r;
            ex_sp  = sp_p1;
            ex_top = t_r;
          end
          default: begin
            // Double dup: second then top go on above the current top.
            ex_we1 = 1'b1;
            ex_wd1 = s_r;
            ex_wr2 = 1'b1;
            ex_wa2 = AW'(sp_p1);
            ex_sp  = sp_p2;
            ex_top = t_r;
          end
        endcase
      end
    end else begin
      unique case (func_r) inside
        FN_IF: begin
          if (sp_r == '0) begin
            ex_stat = ST_UNDERFLOW;
          end else begin
            ex_pop  = t_r;
            ex_sp   = sp_m1;
            ex_top  = (sp_r >= SPW'(2)) ? s_r : '0;
            ex_mode = ($signed(t_r) > 0) ? BR_EXEC : BR_SKIP;
          end
        end
        FN_ELSE:  ex_mode = (mode_r == BR_EXEC) ? BR_SKIP : BR_EXEC;
        FN_ENDIF: ex_mode = BR_NONE;
        default: begin
        end
      endcase
    end
  end

  // Request to the iterative unit: top entry is the left operand.
  always_comb begin
    iter_req.start = (state_r == S_EXEC) && ex_go_iter;
    iter_req.opa   = t_r;
    iter_req.opb   = s_r;
    case (func_r)
      FN_DIV:  iter_req.op = IOP_DIV;
      FN_MOD:  iter_req.op = IOP_MOD;
      default: iter_req.op = IOP_MUL;
    endcase
  end

  sme_iter_unit u_iter (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (iter_req),
    .rsp   (iter_rsp)
  );

  // Single stack write port.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = ex_wa1;
    mem_wd = ex_wd1;
    if (state_r == S_EXEC) begin
      mem_we = ex_we1;
    end else if (state_r == S_ITER) begin
      mem_we = iter_rsp.done;
      mem_wa = AW'(sp_m2);
      mem_wd = iter_rsp.result;
    end else if (state_r == S_WR2) begin
      mem_we = 1'b1;
      mem_wa = wa2_r;
      mem_wd = wd2_r;
    end
  end

  // Stack memory: written at most once a cycle, top two entries read while idle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE) begin
      t_r <= stack_mem[AW'(sp_m1)];
      s_r <= stack_mem[AW'(sp_m2)];
    end
  end

  // Sequencer and architectural state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sp_r        <= '0;
      mode_r      <= BR_NONE;
      out_valid_r <= 1'b0;
    end else begin
      // Output register: loaded by a finished operation, emptied when taken.
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (ex_go_iter) begin
            state_r <= S_ITER;
          end else begin
            sp_r    <= ex_sp;
            mode_r  <= ex_mode;
            state_r <= ex_wr2 ? S_WR2 : S_DONE;
          end
        end
        S_ITER: begin
          if (iter_rsp.done) begin
            sp_r    <= sp_m1;
            state_r <= S_DONE;
          end
        end
        S_WR2: state_r <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      func_r <= in_data.func;
      imm_r  <= in_data.immediate;
    end
    if (state_r == S_EXEC) begin
      res_top_r  <= ex_top;
      res_pop_r  <= ex_pop;
      res_stat_r <= ex_stat;
      wa2_r      <= ex_wa2;
      wd2_r      <= ex_wd2;
    end
    if (state_r == S_ITER && iter_rsp.done) begin
      res_top_r  <= iter_rsp.result;
      res_pop_r  <= '0;
      res_stat_r <= ST_OK;
    end
    if (state_r == S_DONE && out_free) begin
      out_data_r.top_value    <= res_top_r;
      out_data_r.popped_value <= res_pop_r;
      out_data_r.depth        <= DEPTH_W'(sp_r);
      out_data_r.branch_state <= mode_r;
      out_data_r.status       <= res_stat_r;
    end
  end

  // The stack pointer never passes the capacity.
  a_sp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SPW'(STACK_DEPTH))
    else $error("stack pointer beyond capacity");

  // The conditional mode holds only its three defined codes.
  a_mode_valid: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == BR_NONE || mode_r == BR_EXEC || mode_r == BR_SKIP)
    else $error("conditional mode holds an undefined code");

  // The iterative unit answers only while the sequencer waits for it.
  a_iter_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    iter_rsp.done |-> state_r == S_ITER)
    else $error("iterative unit finished outside of its wait state");

  // A skipped stack operation leaves the stack pointer alone.
  a_skip_keeps_sp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && func_r <= FN_DUP2 && mode_r == BR_SKIP) |=> sp_r == $past(sp_r))
    else $error("skipped operation changed the stack pointer");

endmodule

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for the stack machine execute block.
`timescale 1ns / 1ps

module tb;
  import sme_pkg::*;

  localparam int STACK_DEPTH = 1024;
  localparam int TOTAL_OPS   = 800;
  localparam int MAX_IDLE    = 17;
  localparam int DRAIN_WAIT  = 60;
  localparam int MAX_PRINTS  = 40;

  localparam logic [DATA_W-1:0] INT_MIN = 32'h8000_0000;
  localparam logic [DATA_W-1:0] INT_MAX = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] MINUS_1 = 32'hffff_ffff;

  // Undefined operation code with every bit set.
  localparam logic [FUNC_W-1:0] FN_UNDEF_TOP = 5'd31;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  sme_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  sme_out_t out_data;

  stack_machine_execute #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Operations waiting to be driven and results waiting to be seen.
  sme_in_t  pending_ops[$];
  sme_out_t pending_results[$];

  // Shadow copy of the data stack and conditional mode.
  logic [DATA_W-1:0] model_stack [STACK_DEPTH];
  int unsigned       model_sp   = 0;
  logic [BR_W-1:0]   model_mode = BR_NONE;

  int unsigned ops_queued      = 0;
  int unsigned beats_sent      = 0;
  int unsigned results_checked = 0;
  int unsigned error_count     = 0;
  int unsigned status_seen [8];

  logic        in_taken  = 1'b0;
  logic        out_taken = 1'b0;
  int unsigned in_wait   = 0;
  int unsigned out_wait  = 0;
  int unsigned stall_draw;

  initial begin
    forever #4 clk = ~clk;
  end

  // Prints one line per failure, up to a cap, and counts every one.
  task automatic report_error(input string msg);
    if (error_count < MAX_PRINTS) begin
      $display("MISMATCH @%0t: %s", $time, msg);
    end
    error_count++;
  endtask

  // Executes one operation on the shadow stack and returns the result it should give.
  function automatic sme_out_t stack_exec(input sme_in_t op);
    sme_out_t          res;
    logic [DATA_W-1:0] t, s, v, popped, ma, mb, q;
    logic [STAT_W-1:0] st;
    int unsigned       need, room, sp;
    t = '0;
    s = '0;
    v = '0;
    popped = '0;
    st = ST_OK;
    sp = model_sp;
    need = 0;
    room = 0;
    if (op.func <= FN_DUP2) begin
      case (op.func)
        FN_PUSH: begin
          need = 0;
          room = 1;
        end
        FN_POP: need = 1;
        FN_OVER: begin
          need = 2;
          room = 1;
        end
        FN_SWAP: need = 2;
        FN_DUP: begin
          need = 1;
          room = 1;
        end
        FN_DUP2: begin
          need = 2;
          room = 2;
        end
        default: need = 2;
      endcase
      // Skipping wins over the stack checks, and underflow over overflow.
      if (model_mode == BR_SKIP) begin
        st = ST_SKIPPED;
      end else if (sp < need) begin
        st = ST_UNDERFLOW;
      end else if (sp + room > STACK_DEPTH) begin
        st = ST_OVERFLOW;
      end else begin
        if (need >= 1) t = model_stack[sp-1];
        if (need >= 2) s = model_stack[sp-2];
        ma = t[DATA_W-1] ? (0 - t) : t;
        mb = s[DATA_W-1] ? (0 - s) : s;
        case (op.func)
          FN_PUSH: begin
            model_stack[sp] = op.immediate;
            sp++;
          end
          FN_POP: begin
            popped = t;
            sp--;
          end
          FN_OVER: begin
            model_stack[sp] = s;
            sp++;
          end
          FN_SWAP: begin
            model_stack[sp-1] = s;
            model_stack[sp-2] = t;
          end
          FN_DUP: begin
            model_stack[sp] = t;
            sp++;
          end
          FN_DUP2: begin
            model_stack[sp]   = s;
            model_stack[sp+1] = t;
            sp += 2;
          end
          default: begin
            // Binary operations: top entry first, the entry below it second.
            case (op.func)
              FN_ADD: v = t + s;
              FN_SUB: v = t - s;
              FN_MUL: v = t * s;
              FN_DIV: begin
                if (s == '0) begin
                  st = ST_DIV_ZERO;
                end else begin
                  q = ma / mb;
                  v = (t[DATA_W-1] ^ s[DATA_W-1]) ? (0 - q) : q;
                end
              end
              FN_MOD: begin
                if (s == '0) begin
                  st = ST_DIV_ZERO;
                end else begin
                  q = ma % mb;
                  v = t[DATA_W-1] ? (0 - q) : q;
                end
              end
              FN_LT: v = ($signed(t) < $signed(s)) ? 1 : 0;
              FN_LE: v = ($signed(t) <= $signed(s)) ? 1 : 0;
              FN_EQ: v = (t == s) ? 1 : 0;
              default: v = (t != s) ? 1 : 0;
            endcase
            if (st == ST_OK) begin
              model_stack[sp-2] = v;
              sp--;
            end
          end
        endcase
      end
    end else if (op.func == FN_IF) begin
      // IF is evaluated in every mode and consumes the top entry.
      if (sp < 1) begin
        st = ST_UNDERFLOW;
      end else begin
        popped = model_stack[sp-1];
        sp--;
        model_mode = (!popped[DATA_W-1] && popped != '0) ? BR_EXEC : BR_SKIP;
      end
    end else if (op.func == FN_ELSE) begin
      model_mode = (model_mode == BR_EXEC) ? BR_SKIP : BR_EXEC;
    end else if (op.func == FN_ENDIF) begin
      model_mode = BR_NONE;
    end
    model_sp = sp;
    res.top_value    = (sp > 0) ? model_stack[sp-1] : '0;
    res.popped_value = popped;
    res.depth        = sp[DEPTH_W-1:0];
    res.branch_state = model_mode;
    res.status       = st;
    return res;
  endfunction

  task automatic add_op(input logic [FUNC_W-1:0] f, input logic [DATA_W-1:0] v);
    sme_in_t op;
    op.func      = f;
    op.immediate = v;
    pending_ops.push_back(op);
    ops_queued++;
  endtask

  // Operand values weighted toward the corners of signed arithmetic.
  function automatic logic [DATA_W-1:0] pick_operand();
    int small_val;
    small_val = int'($urandom_range(0, 40)) - 20;
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 1;
      2: return MINUS_1;
      3: return INT_MIN;
      4: return INT_MAX;
      5: return DATA_W'(small_val);
      default: return $urandom;
    endcase
  endfunction

  // Idle cycles before a beat; every fourth stretch of 40 beats runs back to back.
  function automatic int unsigned idle_draw(input int unsigned k);
    if ((k / 40) % 4 == 3) return 0;
    return $urandom_range(0, MAX_IDLE);
  endfunction

  // Doubles a pair up to the full capacity, probes overflow there, then pops a few.
  task automatic fill_to_capacity();
    add_op(FN_ENDIF, $urandom);
    add_op(FN_PUSH, pick_operand());
    add_op(FN_PUSH, pick_operand());
    repeat (STACK_DEPTH / 2) add_op(FN_DUP2, '0);
    add_op(FN_DUP, '0);
    add_op(FN_OVER, '0);
    add_op(FN_PUSH, $urandom);
    add_op(FN_DUP2, '0);
    add_op(FN_ADD, '0);
    add_op(FN_DUP2, '0);
    add_op(FN_DUP, '0);
    add_op(FN_SWAP, '0);
    add_op(FN_MUL, '0);
    repeat (8) add_op(FN_POP, $urandom);
  endtask

  // Builds the whole operation list: directed corners first, then random sequences.
  initial begin
    bit filled;
    filled = 1'b0;

    // Empty-stack errors, an undefined code and ELSE with no open region.
    add_op(FN_POP, '0);
    add_op(FN_IF, '0);
    add_op(FN_UNDEF_TOP, MINUS_1);
    add_op(FN_ELSE, '0);
    add_op(FN_ENDIF, '0);
    // Most negative value divided by minus one, as quotient and remainder.
    add_op(FN_PUSH, '0);
    add_op(FN_PUSH, MINUS_1);
    add_op(FN_PUSH, INT_MIN);
    add_op(FN_DUP2, '0);
    add_op(FN_DIV, '0);
    add_op(FN_POP, '0);
    add_op(FN_MOD, '0);
    // Divide by zero for both div and mod.
    add_op(FN_PUSH, 5);
    add_op(FN_DIV, '0);
    add_op(FN_MOD, '0);
    // Wrapping arithmetic and the remaining stack operations and comparisons.
    add_op(FN_PUSH, INT_MAX);
    add_op(FN_ADD, '0);
    add_op(FN_SWAP, '0);
    add_op(FN_DUP, '0);
    add_op(FN_OVER, '0);
    add_op(FN_MUL, '0);
    add_op(FN_SUB, '0);
    add_op(FN_LT, '0);
    add_op(FN_LE, '0);
    add_op(FN_PUSH, INT_MIN);
    add_op(FN_EQ, '0);
    add_op(FN_NE, '0);
    // A false condition, a skipped operation, then the other branch.
    add_op(FN_IF, '0);
    add_op(FN_PUSH, 7);
    add_op(FN_ELSE, '0);
    add_op(FN_ENDIF, '0);

    while (ops_queued < TOTAL_OPS) begin
      if (!filled && ops_queued >= TOTAL_OPS / 5) begin
        fill_to_capacity();
        filled = 1'b1;
      end
      case ($urandom_range(0, 99)) inside
        [0:34]: begin
          // Two operands and a binary operation.
          add_op(FN_PUSH, pick_operand());
          add_op(FN_PUSH, pick_operand());
          add_op(5'($urandom_range(FN_ADD, FN_NE)), $urandom);
        end
        [35:59]: begin
          // Conditional region with random bodies; sometimes left open.
          add_op(FN_PUSH, pick_operand());
          add_op(FN_IF, $urandom);
          repeat ($urandom_range(0, 3)) add_op(5'($urandom_range(0, 14)), pick_operand());
          if ($urandom_range(0, 1) == 1) begin
            add_op(FN_ELSE, $urandom);
            repeat ($urandom_range(0, 3)) add_op(5'($urandom_range(0, 16)), pick_operand());
          end
          if ($urandom_range(0, 6) != 0) add_op(FN_ENDIF, $urandom);
        end
        [60:79]: begin
          if ($urandom_range(0, 1) == 1) add_op(FN_PUSH, pick_operand());
          add_op(5'($urandom_range(FN_POP, FN_DUP2)), $urandom);
        end
        [80:92]: add_op(5'($urandom_range(FN_PUSH, FN_ENDIF)), pick_operand());
        default: add_op(5'($urandom_range(0, 31)), $urandom);
      endcase
    end
  end

  // Input driver: presents queued beats at the falling edge, with random gaps.
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_taken) begin
        // Beat still waiting for ready; hold it.
      end else if (in_wait != 0) begin
        in_valid <= 1'b0;
        in_wait  <= in_wait - 1;
      end else if (pending_ops.size() != 0) begin
        in_data    <= pending_ops.pop_front();
        in_valid   <= 1'b1;
        in_wait    <= idle_draw(beats_sent);
        beats_sent <= beats_sent + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result back-pressure: a random stall after every accepted result.
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_taken) begin
        stall_draw = idle_draw(results_checked);
        out_wait  <= stall_draw;
        out_ready <= (stall_draw == 0);
      end else if (out_wait != 0) begin
        out_wait  <= out_wait - 1;
        out_ready <= (out_wait == 1);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor: checks each result beat against the oldest prediction, then predicts new beats.
  always @(posedge clk) begin
    sme_out_t want;
    if (!rst_n) begin
      in_taken  <= 1'b0;
      out_taken <= 1'b0;
    end else begin
      in_taken  <= in_valid && in_ready;
      out_taken <= out_valid && out_ready;
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_error($sformatf("result beat with nothing expected: %p", out_data));
        end else begin
          want = pending_results.pop_front();
          if (out_data.top_value !== want.top_value)
            report_error($sformatf("beat %0d top_value got %h want %h",
                                   results_checked, out_data.top_value, want.top_value));
          if (out_data.popped_value !== want.popped_value)
            report_error($sformatf("beat %0d popped_value got %h want %h",
                                   results_checked, out_data.popped_value,
                                   want.popped_value));
          if (out_data.depth !== want.depth)
            report_error($sformatf("beat %0d depth got %0d want %0d",
                                   results_checked, out_data.depth, want.depth));
          if (out_data.branch_state !== want.branch_state)
            report_error($sformatf("beat %0d branch_state got %0d want %0d",
                                   results_checked, out_data.branch_state,
                                   want.branch_state));
          if (out_data.status !== want.status)
            report_error($sformatf("beat %0d status got %0d want %0d",
                                   results_checked, out_data.status, want.status));
          status_seen[want.status]++;
        end
        results_checked++;
      end
      if (in_valid && in_ready) begin
        pending_results.push_back(stack_exec(in_data));
      end
    end
  end

  // Reset, wait for the stimulus to drain, then judge the run.
  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (pending_ops.size() != 0 || in_valid || pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_WAIT) @(posedge clk);
    if (pending_results.size() != 0) begin
      report_error($sformatf("%0d results never arrived", pending_results.size()));
    end
    $display("Sent %0d operations and checked %0d results; %0d mismatches.",
             beats_sent, results_checked, error_count);
    $display("Status mix: ok %0d, underflow %0d, overflow %0d, div by zero %0d, skipped %0d.",
             status_seen[ST_OK], status_seen[ST_UNDERFLOW], status_seen[ST_OVERFLOW],
             status_seen[ST_DIV_ZERO], status_seen[ST_SKIPPED]);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #(20_000_000);
    $display("Run timed out with %0d results outstanding.", pending_results.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
